>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/rsaoc_pkg.sv
// shared types and constants of the rsa offset cipher core
package rsaoc_pkg;

    localparam int OFFSET_BITS = 16;

    // configuration register indexes
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // reset values of the configuration registers
    localparam logic [31:0] RESET_MODULUS     = 32'd9173503;
    localparam logic [31:0] RESET_PUBLIC_EXP  = 32'd17;
    localparam logic [31:0] RESET_PRIVATE_EXP = 32'd539257;

    // status of the modular multiply unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

>>> hw/rtl/rsaoc_modmul.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`include "assert_macros.svh"

module rsaoc_modmul #(
    parameter int WORD_BITS = 32,
    parameter int ARG_BITS  = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ARG_BITS-1:0]   i_a,
    input  logic [WORD_BITS-1:0]  i_b,
    input  logic [WORD_BITS-1:0]  i_m,
    output rsaoc_pkg::t_mm_stat   o_stat,
    output logic [WORD_BITS-1:0]  o_p
);

    localparam int CW = (ARG_BITS > 1) ? $clog2(ARG_BITS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(ARG_BITS - 1);

    logic                  r_run;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [ARG_BITS-1:0]   r_a;
    logic [WORD_BITS-1:0]  r_b;
    logic [WORD_BITS-1:0]  r_m;
    logic [WORD_BITS-1:0]  r_acc;

    logic [WORD_BITS+1:0]  s_t;
    logic [WORD_BITS+1:0]  s_t1;
    logic [WORD_BITS+1:0]  s_t2;
    logic [WORD_BITS+1:0]  s_mw;

    // acc < m and b < m, so 2*acc + b < 3m: two conditional subtracts
    always_comb begin
        s_mw = {2'b00, r_m};
        s_t  = {1'b0, r_acc, 1'b0} + (r_a[ARG_BITS-1] ? {2'b00, r_b} : '0);
        s_t1 = (s_t >= s_mw) ? (s_t - s_mw) : s_t;
        s_t2 = (s_t1 >= s_mw) ? (s_t1 - s_mw) : s_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_run) begin
            r_a   <= {r_a[ARG_BITS-2:0], 1'b0};
            r_acc <= s_t2[WORD_BITS-1:0];
        end
    end

    assign o_stat.busy = r_run;
    assign o_stat.done = r_done;
    assign o_p         = r_acc;

    `ASSERT_NEVER(a_done_while_run, i_clk, i_rst_n, r_done && r_run)
    `ASSERT_PROP(a_done_single, i_clk, i_rst_n, r_done |=> !r_done)
    `ASSERT_PROP(a_acc_reduced, i_clk, i_rst_n, (r_run && !$past(i_start)) |-> (r_acc < r_m))

endmodule

>>> hw/rtl/rsa_offset_char_cipher_core.sv
// rsa offset cipher core: sequencer for square-and-multiply modular exponentiation
//
// usage: a transaction is accepted at a clock edge with start high and busy low;
// i_cmd selects encrypt (value + offset, reduced, raised to the public exponent)
// or decrypt (value raised to the private exponent, then minus offset mod 2^W).
// busy stays high from the accepting edge until the result is shown.
// the result sits on o_result for one cycle with o_valid high; the receiver
// cannot stall, it must take it in that cycle.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 modulus,
// 1 public exponent, 2 private exponent, 3 ignored); write only while idle.
// operation: one shared bit-serial modular multiplier does all the work, with a
// multiplier operand of AW = max(W,16)+1 bits. one reduction pass, then for
// each of the W exponent bits one issue state, for a set bit one multiply, and
// then one square. a modulus of 0 or 1 skips the exponentiation and goes
// straight to the finishing state with an accumulator of 0.
// one transaction at a time; the next can be accepted in the o_valid cycle.
// reset: the configuration registers take their reset values, the core goes idle, no result pends.
`include "assert_macros.svh"

module rsa_offset_char_cipher_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [WORD_BITS-1:0]                i_value,
    input  logic [rsaoc_pkg::OFFSET_BITS-1:0]   i_offset,
    output logic                                o_valid,
    output logic [WORD_BITS-1:0]                o_result,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [WORD_BITS-1:0]                i_cfg_data
);

    localparam int ARG_BITS = ((WORD_BITS > rsaoc_pkg::OFFSET_BITS) ?
                               WORD_BITS : rsaoc_pkg::OFFSET_BITS) + 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam logic [BW-1:0] LAST_BIT = BW'(WORD_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RED  = 6'b000010,
        ST_EXP  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_SQR  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    logic [WORD_BITS-1:0]           r_modulus, r_pub_exp, r_priv_exp;
    logic                           r_cmd, n_cmd;
    logic [rsaoc_pkg::OFFSET_BITS-1:0] r_offset, n_offset;
    logic [WORD_BITS-1:0]           r_exp, n_exp;
    logic [WORD_BITS-1:0]           r_acc, n_acc;
    logic [WORD_BITS-1:0]           r_base, n_base;
    logic [BW-1:0]                  r_bit, n_bit;
    logic                           r_valid, n_valid;
    logic [WORD_BITS-1:0]           r_result, n_result;

    logic                           s_mm_start;
    logic [ARG_BITS-1:0]            s_mm_a;
    logic [WORD_BITS-1:0]           s_mm_b;
    logic [WORD_BITS-1:0]           s_mm_p;
    rsaoc_pkg::t_mm_stat            s_mm_stat;
    logic                           s_mod_trivial;
    logic                           s_mm_wait;

    assign s_mod_trivial = (r_modulus[WORD_BITS-1:1] == '0);
    assign s_mm_wait     = (r_state == ST_RED) || (r_state == ST_MUL) || (r_state == ST_SQR);

    rsaoc_modmul #(
        .WORD_BITS (WORD_BITS),
        .ARG_BITS  (ARG_BITS)
    ) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_mm_start),
        .i_a     (s_mm_a),
        .i_b     (s_mm_b),
        .i_m     (r_modulus),
        .o_stat  (s_mm_stat),
        .o_p     (s_mm_p)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_offset   = r_offset;
        n_exp      = r_exp;
        n_acc      = r_acc;
        n_base     = r_base;
        n_bit      = r_bit;
        n_valid    = 1'b0;
        n_result   = r_result;
        s_mm_start = 1'b0;
        s_mm_a     = ARG_BITS'(r_base);
        s_mm_b     = r_base;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_offset = i_offset;
                    n_exp    = (i_cmd == rsaoc_pkg::CMD_DECRYPT) ? r_priv_exp : r_pub_exp;
                    if (s_mod_trivial) begin
                        n_acc   = '0;
                        n_state = ST_FIN;
                    end else begin
                        // reduce the base as base * 1 mod m
                        s_mm_start = 1'b1;
                        s_mm_b     = WORD_BITS'(1);
                        if (i_cmd == rsaoc_pkg::CMD_DECRYPT) begin
                            s_mm_a = ARG_BITS'(i_value);
                        end else begin
                            s_mm_a = ARG_BITS'(i_value) + ARG_BITS'(i_offset);
                        end
                        n_state = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (s_mm_stat.done) begin
                    n_base  = s_mm_p;
                    n_acc   = WORD_BITS'(1);
                    n_bit   = '0;
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                s_mm_start = 1'b1;
                if (r_exp[0]) begin
                    s_mm_a  = ARG_BITS'(r_acc);
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (s_mm_stat.done) begin
                    n_acc      = s_mm_p;
                    s_mm_start = 1'b1;
                    n_state    = ST_SQR;
                end
            end
            ST_SQR: begin
                if (s_mm_stat.done) begin
                    n_base = s_mm_p;
                    n_exp  = {1'b0, r_exp[WORD_BITS-1:1]};
                    n_bit  = r_bit + 1'b1;
                    n_state = (r_bit == LAST_BIT) ? ST_FIN : ST_EXP;
                end
            end
            ST_FIN: begin
                n_valid  = 1'b1;
                n_result = (r_cmd == rsaoc_pkg::CMD_DECRYPT) ?
                           (r_acc - WORD_BITS'(r_offset)) : r_acc;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= 1'b0;
            r_modulus  <= WORD_BITS'(rsaoc_pkg::RESET_MODULUS);
            r_pub_exp  <= WORD_BITS'(rsaoc_pkg::RESET_PUBLIC_EXP);
            r_priv_exp <= WORD_BITS'(rsaoc_pkg::RESET_PRIVATE_EXP);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsaoc_pkg::REG_MODULUS:     r_modulus  <= i_cfg_data;
                    rsaoc_pkg::REG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                    rsaoc_pkg::REG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_offset <= n_offset;
        r_exp    <= n_exp;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_bit    <= n_bit;
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `ASSERT_PROP(a_valid_when_idle, i_clk, i_rst_n, o_valid |-> !busy)
    `ASSERT_PROP(a_accept_goes_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_PROP(a_done_expected, i_clk, i_rst_n, s_mm_stat.done |-> s_mm_wait)
    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, s_mm_start && s_mm_stat.busy)

endmodule

>>> sim/rsa_cipher_watch.sv
// result monitor for the rsa offset cipher core: predicts each result and compares it
module rsa_cipher_watch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cmd,
    input  logic [31:0] i_value,
    input  logic [15:0] i_offset,
    input  logic        i_valid,
    input  logic [31:0] i_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors,
    output int          o_checked
);

    logic [31:0] modulus_q;
    logic [31:0] pub_exp_q;
    logic [31:0] priv_exp_q;
    logic [31:0] words_due[$];
    logic [31:0] want;
    int          err_count = 0;
    int          checked_count = 0;

    assign o_errors  = err_count;
    assign o_checked = checked_count;

    // square-and-multiply over all 32 exponent bits, products fit in 64 bits
    function automatic logic [63:0] mod_exp(input logic [63:0] base,
                                            input logic [31:0] exponent,
                                            input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] b;
        acc = 64'd1;
        b   = base;
        if (m <= 64'd1)
            return 64'd0;
        b = b % m;
        for (int i = 0; i < 32; i++) begin
            if (exponent[i])
                acc = (acc * b) % m;
            b = (b * b) % m;
        end
        return acc;
    endfunction

    function automatic logic [31:0] cipher_word(input logic cmd, input logic [31:0] value,
                                                input logic [15:0] offset);
        logic [63:0] sum;
        logic [63:0] power;
        if (cmd == rsaoc_pkg::CMD_ENCRYPT) begin
            // sum is formed exactly, then reduced
            sum = {32'd0, value} + {48'd0, offset};
            if (modulus_q > 32'd1)
                sum = sum % {32'd0, modulus_q};
            power = mod_exp(sum, pub_exp_q, {32'd0, modulus_q});
            return power[31:0];
        end
        power = mod_exp({32'd0, value}, priv_exp_q, {32'd0, modulus_q});
        return power[31:0] - {16'd0, offset};
    endfunction

    task automatic report(input string msg);
        err_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_q  = rsaoc_pkg::RESET_MODULUS;
            pub_exp_q  = rsaoc_pkg::RESET_PUBLIC_EXP;
            priv_exp_q = rsaoc_pkg::RESET_PRIVATE_EXP;
            words_due.delete();
            o_pending <= 0;
        end else begin
            // the older transaction is retired before a new one is queued
            if (i_valid === 1'b1) begin
                if (words_due.size() == 0) begin
                    report($sformatf("result %08h with no transaction outstanding", i_result));
                end else begin
                    want = words_due.pop_front();
                    checked_count++;
                    if (i_result !== want)
                        report($sformatf("result %08h, expected %08h", i_result, want));
                end
            end
            if (i_start && !i_busy)
                words_due = {words_due, cipher_word(i_cmd, i_value, i_offset)};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsaoc_pkg::REG_MODULUS:     modulus_q  = i_cfg_data;
                    rsaoc_pkg::REG_PUBLIC_EXP:  pub_exp_q  = i_cfg_data;
                    rsaoc_pkg::REG_PRIVATE_EXP: priv_exp_q = i_cfg_data;
                    default: ;
                endcase
            end
            o_pending <= words_due.size();
        end
    end

endmodule

>>> sim/tb_rsa_offset_char_cipher_core.sv
// testbench top for the rsa offset cipher core: stimulus, config phases and verdict
module tb_rsa_offset_char_cipher_core;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 4_000_000;
    localparam int         SETTLE_CYCLES = 2500;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [31:0] i_value;
    logic [15:0] i_offset;
    logic        o_valid;
    logic [31:0] o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int          pending;
    int          errors;
    int          checked;
    int          items_sent = 0;
    int          writes_done = 0;
    int          cycles = 0;
    logic [31:0] modulus_now;
    bit          back_to_back;

    rsa_offset_char_cipher_core #(
        .WORD_BITS(32)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_value   (i_value),
        .i_offset  (i_offset),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    rsa_cipher_watch watch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_cmd     (i_cmd),
        .i_value   (i_value),
        .i_offset  (i_offset),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_pending (pending),
        .o_errors  (errors),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // start is left high on return so a following transaction can go back to back
    task automatic send_item(input logic cmd, input logic [31:0] value,
                             input logic [15:0] offset);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap - 1) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_cmd    <= cmd;
        i_value  <= value;
        i_offset <= offset;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == rsaoc_pkg::REG_MODULUS)
            modulus_now = data;
        writes_done++;
    endtask

    task automatic set_config(input logic [31:0] m, input logic [31:0] e,
                              input logic [31:0] d);
        drain();
        write_reg(rsaoc_pkg::REG_MODULUS, m);
        write_reg(rsaoc_pkg::REG_PUBLIC_EXP, e);
        write_reg(rsaoc_pkg::REG_PRIVATE_EXP, d);
    endtask

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(2, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        logic        cmd;
        logic [31:0] value;
        logic [15:0] offset;
        int          pick;
        cmd  = $urandom_range(0, 1) ? rsaoc_pkg::CMD_DECRYPT : rsaoc_pkg::CMD_ENCRYPT;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            value = $urandom_range(0, 255);
        else if (pick < 70)
            value = $urandom;
        else if (pick < 85)
            value = (modulus_now > 32'd1) ? $urandom % modulus_now : $urandom;
        else begin
            case ($urandom_range(0, 3))
                0:       value = 32'd0;
                1:       value = 32'hFFFF_FFFF;
                2:       value = modulus_now - 32'd1;
                default: value = modulus_now;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            offset = 16'd0;
        else if (pick < 70)
            offset = 16'($urandom_range(0, 255));
        else if (pick < 80)
            offset = 16'hFFFF;
        else
            offset = 16'($urandom_range(0, 65535));
        send_item(cmd, value, offset);
    endtask

    initial begin
        start        <= 1'b0;
        i_cmd        <= rsaoc_pkg::CMD_ENCRYPT;
        i_value      <= 32'd0;
        i_offset     <= 16'd0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= rsaoc_pkg::REG_MODULUS;
        i_cfg_data   <= 32'd0;
        i_rst_n      <= 1'b0;
        back_to_back = 1'b0;
        modulus_now  = rsaoc_pkg::RESET_MODULUS;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: header item, characters, extremes of both fields
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd0, 16'd0);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd72, 16'd0);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd255, 16'hFFFF);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd0, 16'd0);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 16'd0);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd1, 16'hFFFF);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd9173502, 16'd1234);

        // a write to the unused index must leave the registers alone
        drain();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd65, 16'd7);

        // largest modulus, all-ones and zero exponents, sums past 2^32
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFE, 16'd1);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd12345, 16'd0);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 16'hFFFF);

        // modulus of one, then of zero
        drain();
        write_reg(rsaoc_pkg::REG_MODULUS, 32'd1);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd5, 16'd3);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        drain();
        write_reg(rsaoc_pkg::REG_MODULUS, 32'd0);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd7, 16'd0);

        set_config(32'd2, 32'd0, 32'd1);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd3, 16'd0);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd3, 16'd2);
        set_config(32'd2579, 32'd1, 32'hFFFF_FFFF);
        send_item(rsaoc_pkg::CMD_ENCRYPT, 32'd2578, 16'd1);
        send_item(rsaoc_pkg::CMD_DECRYPT, 32'd2580, 16'd0);

        // random segments, each under its own key set; one runs without gaps
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 0)
                set_config(rsaoc_pkg::RESET_MODULUS, rsaoc_pkg::RESET_PUBLIC_EXP,
                           rsaoc_pkg::RESET_PRIVATE_EXP);
            else begin
                case ($urandom_range(0, 9))
                    0:       set_config(32'd1, pick_exponent(), pick_exponent());
                    1:       set_config(32'd0, pick_exponent(), pick_exponent());
                    2, 3:    set_config($urandom_range(2, 1000), pick_exponent(),
                                        pick_exponent());
                    default: set_config($urandom, pick_exponent(), pick_exponent());
                endcase
            end
            back_to_back = (seg == 2);
            repeat (45) begin
                random_item();
                if ($urandom_range(0, 29) == 0)
                    drain();
            end
        end
        back_to_back = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d transactions and %0d register writes: reset keys, modulus 0, 1, 2",
                 items_sent, writes_done);
        $display("and all-ones, zero and all-ones exponents; %0d results compared, %0d mismatches",
                 checked, errors);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
